### hdl/dvc_pkg.sv
`default_nettype none

package dvc_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int CLOCK_BITS  = 32;
  localparam int IDXW        = $clog2(MAX_PROCS);
  localparam int CNTW        = $clog2(MAX_PROCS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CLOCK_BITS-1:0] clk_t;
  typedef logic [IDXW-1:0]       idx_t;
  typedef logic [CNTW-1:0]       cnt_t;
  typedef logic [1:0]            kind_t;

  localparam clk_t CLOCK_MAX = '1;

  localparam kind_t KIND_INTERNAL   = 2'd0;
  localparam kind_t KIND_SEND       = 2'd1;
  localparam kind_t KIND_RECV_BEGIN = 2'd2;
  localparam kind_t KIND_ENTRY      = 2'd3;

  typedef enum logic [1:0] {
    OP_BUMP,
    OP_SEND,
    OP_MERGE
  } op_t;

  typedef struct packed {
    op_t  op;
    idx_t slot;
    clk_t value;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_BUMP,
    B_RX_CMP,
    B_RX_WR,
    B_SEND_LS,
    B_SCAN,
    B_FLUSH
  } back_st_t;

  // 4-bit process number folded into the vector by repeated subtraction
  function automatic idx_t slot_of(input logic [3:0] v);
    logic [6:0] r;
    r = 7'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= 7'(MAX_PROCS)) begin
        r = r - 7'(MAX_PROCS);
      end
    end
    return r[IDXW-1:0];
  endfunction

  // received value clipped to the clock range
  function automatic clk_t sat_in(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'(CLOCK_MAX)) begin
      return CLOCK_MAX;
    end
    return clk_t'(w);
  endfunction

  function automatic clk_t sat_inc(input clk_t c);
    return (c == CLOCK_MAX) ? c : clk_t'(c + clk_t'(1));
  endfunction

endpackage

`default_nettype wire

### hdl/dvc_in_if.sv
`default_nettype none

interface dvc_in_if;
  import dvc_pkg::*;

  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [3:0]  dest;
  logic [3:0]  entry_index;
  logic [31:0] entry_value;

  modport source (output valid, kind, dest, entry_index, entry_value, input ready);
  modport sink   (input valid, kind, dest, entry_index, entry_value, output ready);
endinterface

`default_nettype wire

### hdl/dvc_out_if.sv
`default_nettype none

interface dvc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_index;
  logic [31:0] out_value;
  logic        empty_res;
  logic        last;

  modport source (output valid, out_index, out_value, empty_res, last, input ready);
  modport sink   (input valid, out_index, out_value, empty_res, last, output ready);
endinterface

`default_nettype wire

### hdl/differential_vector_clock_unit.sv
`default_nettype none

// Channel   Dir  Handshake          Request contents
// in_req    in   valid/ready        kind, dest, entry_index, entry_value
// out_res   out  valid/ready        out_index, out_value, empty_res, last
// cfg       in   APB psel/penable   paddr 0: own_id, paddr 4: process_count
//
// Internal tick, receive begin: bump own entry. Entry: write, stamp if raised.
// Send: scan min(process_count, 16) entries, flush, bump; the single read port
// of each RAM sets one entry per cycle unless stalled. A two-deep command queue
// lets the front keep taking requests while the back works or the output stalls.
// Synchronous active-low reset clears control and the per-entry valid bits,
// so all clock state reads as zero straight out of reset; no clearing pass.
// A held output request stalls the scan only when a second hit needs the slot.
module differential_vector_clock_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  dvc_in_if.sink           in_req,
  dvc_out_if.source        out_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import dvc_pkg::*;

  localparam logic REG_OWN_ID   = 1'b0;
  localparam logic REG_PROC_CNT = 1'b1;
  localparam logic [4:0] PROC_CNT_RST = 5'd16;

  logic [3:0] own_id_r, own_id_nxt;
  logic [4:0] proc_cnt_r, proc_cnt_nxt;
  logic       cfg_wr;

  cmd_t push_cmd, q_head;
  logic push, q_pop, q_empty, q_full;
  idx_t own_slot;
  cnt_t scan_n;

  // APB: zero wait states, registers decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    own_id_nxt   = own_id_r;
    proc_cnt_nxt = proc_cnt_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_OWN_ID:   own_id_nxt   = pwdata[3:0];
        REG_PROC_CNT: proc_cnt_nxt = pwdata[4:0];
        default:      own_id_nxt   = own_id_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_ID:   prdata = 32'(own_id_r);
      REG_PROC_CNT: prdata = 32'(proc_cnt_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r   <= '0;
      proc_cnt_r <= PROC_CNT_RST;
    end else begin
      own_id_r   <= own_id_nxt;
      proc_cnt_r <= proc_cnt_nxt;
    end
  end

  // own index folds into the vector; scan length clamps to its size
  assign own_slot = slot_of(own_id_r);
  assign scan_n   = (7'(proc_cnt_r) > 7'(MAX_PROCS)) ? cnt_t'(MAX_PROCS)
                                                     : cnt_t'(proc_cnt_r);

  // front: takes requests and turns them into queue commands
  dvc_front u_front (
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dvc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: owns the clock, stamp and send-time RAMs and the output register
  dvc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .own_slot (own_slot),
    .scan_n   (scan_n),
    .out_res  (out_res)
  );

endmodule

`default_nettype wire

### hdl/dvc_ram.sv
`default_nettype none

module dvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/dvc_front.sv
`default_nettype none

module dvc_front (
  dvc_in_if.sink         in_req,
  input  wire logic      q_full,
  output logic           push,
  output dvc_pkg::cmd_t  push_cmd
);
  import dvc_pkg::*;

  logic       drop;
  logic [6:0] eidx7;

  assign in_req.ready = !q_full;
  assign eidx7        = 7'(in_req.entry_index);

  always_comb begin
    drop           = 1'b0;
    push_cmd.op    = OP_BUMP;
    push_cmd.slot  = '0;
    push_cmd.value = sat_in(in_req.entry_value);
    case (in_req.kind)
      KIND_INTERNAL, KIND_RECV_BEGIN: begin
        push_cmd.op = OP_BUMP;
      end
      KIND_SEND: begin
        push_cmd.op   = OP_SEND;
        push_cmd.slot = slot_of(in_req.dest);
      end
      KIND_ENTRY: begin
        push_cmd.op   = OP_MERGE;
        push_cmd.slot = eidx7[IDXW-1:0];
        // entries for processes outside the vector are discarded here
        drop          = (eidx7 >= 7'(MAX_PROCS));
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  assign push = in_req.valid && in_req.ready && !drop;

endmodule

`default_nettype wire

### hdl/dvc_queue.sv
`default_nettype none

module dvc_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dvc_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output dvc_pkg::cmd_t       head,
  output logic                empty,
  output logic                full
);
  import dvc_pkg::*;

  cmd_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wp_r, wp_nxt;
  logic [QPW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCW'(QUEUE_DEPTH));
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wp_r + 1'b1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rp_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = QCW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### hdl/dvc_back.sv
`default_nettype none

module dvc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dvc_pkg::cmd_t  q_head,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire dvc_pkg::idx_t  own_slot,
  input  wire dvc_pkg::cnt_t  scan_n,
  dvc_out_if.source           out_res
);
  import dvc_pkg::*;

  back_st_t st_r, st_nxt;

  cmd_t cur_r, cur_nxt;
  clk_t ls_r, ls_nxt;
  cnt_t issue_r, issue_nxt;
  logic dv_r, dv_nxt;
  idx_t di_r, di_nxt;
  logic pend_v_r, pend_v_nxt;
  idx_t pend_idx_r, pend_idx_nxt;
  clk_t pend_val_r, pend_val_nxt;
  logic same_r, same_nxt;

  logic        out_vld_r, out_vld_nxt;
  logic [3:0]  out_idx_r, out_idx_nxt;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_empty_r, out_empty_nxt;
  logic        out_last_r, out_last_nxt;

  logic [MAX_PROCS-1:0] cv_vld_r, cv_vld_nxt;
  logic [MAX_PROCS-1:0] ua_vld_r, ua_vld_nxt;
  logic [MAX_PROCS-1:0] sa_vld_r, sa_vld_nxt;
  logic cv_rv_r, cv_rv_nxt;
  logic ua_rv_r, ua_rv_nxt;
  logic sa_rv_r, sa_rv_nxt;

  logic cv_we, cv_re, ua_we, ua_re, sa_we, sa_re;
  idx_t cv_waddr, cv_raddr, ua_waddr, ua_raddr, sa_waddr, sa_raddr;
  clk_t cv_wdata, ua_wdata, sa_wdata;
  clk_t cv_rdata, ua_rdata, sa_rdata;
  clk_t cv_d, ua_d, sa_d;

  logic        push, push_empty, push_last;
  logic [3:0]  push_idx;
  logic [31:0] push_val;
  logic        out_free, hit, blocked;
  clk_t        nv;

  dvc_ram #(.WIDTH(CLOCK_BITS), .DEPTH(MAX_PROCS)) u_cv_ram (
    .clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(cv_wdata),
    .re(cv_re), .raddr(cv_raddr), .rdata(cv_rdata)
  );

  dvc_ram #(.WIDTH(CLOCK_BITS), .DEPTH(MAX_PROCS)) u_ua_ram (
    .clk(clk), .we(ua_we), .waddr(ua_waddr), .wdata(ua_wdata),
    .re(ua_re), .raddr(ua_raddr), .rdata(ua_rdata)
  );

  dvc_ram #(.WIDTH(CLOCK_BITS), .DEPTH(MAX_PROCS)) u_sa_ram (
    .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
    .re(sa_re), .raddr(sa_raddr), .rdata(sa_rdata)
  );

  // never-written entries read as zero
  assign cv_d = cv_rv_r ? cv_rdata : '0;
  assign ua_d = ua_rv_r ? ua_rdata : '0;
  assign sa_d = sa_rv_r ? sa_rdata : '0;

  assign out_free = !out_vld_r || out_res.ready;
  assign nv       = sat_inc(cv_d);
  assign hit      = dv_r && (ls_r < ua_d);
  // a hit can only retire when the held entry has somewhere to go
  assign blocked  = hit && pend_v_r && !out_free;

  always_comb begin
    st_nxt       = st_r;
    cur_nxt      = cur_r;
    ls_nxt       = ls_r;
    issue_nxt    = issue_r;
    dv_nxt       = dv_r;
    di_nxt       = di_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_val_nxt = pend_val_r;
    same_nxt     = same_r;
    q_pop        = 1'b0;
    cv_we = 1'b0; cv_waddr = '0; cv_wdata = '0; cv_re = 1'b0; cv_raddr = '0;
    ua_we = 1'b0; ua_waddr = '0; ua_wdata = '0; ua_re = 1'b0; ua_raddr = '0;
    sa_we = 1'b0; sa_waddr = '0; sa_wdata = '0; sa_re = 1'b0; sa_raddr = '0;
    push       = 1'b0;
    push_idx   = '0;
    push_val   = '0;
    push_empty = 1'b0;
    push_last  = 1'b0;

    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          case (q_head.op)
            OP_BUMP: begin
              cv_re    = 1'b1;
              cv_raddr = own_slot;
              st_nxt   = B_BUMP;
            end
            OP_MERGE: begin
              cv_re    = 1'b1;
              cv_raddr = q_head.slot;
              st_nxt   = B_RX_CMP;
            end
            OP_SEND: begin
              sa_re    = 1'b1;
              sa_raddr = q_head.slot;
              st_nxt   = B_SEND_LS;
            end
            default: begin
              st_nxt = B_IDLE;
            end
          endcase
        end
      end
      B_BUMP: begin
        cv_we    = 1'b1;
        cv_waddr = own_slot;
        cv_wdata = nv;
        ua_we    = 1'b1;
        ua_waddr = own_slot;
        ua_wdata = nv;
        if (cur_r.op == OP_SEND) begin
          sa_we    = 1'b1;
          sa_waddr = cur_r.slot;
          sa_wdata = nv;
        end
        st_nxt = B_IDLE;
      end
      B_RX_CMP: begin
        if (cur_r.value > cv_d) begin
          cv_we    = 1'b1;
          cv_waddr = cur_r.slot;
          cv_wdata = cur_r.value;
          cv_re    = 1'b1;
          cv_raddr = own_slot;
          same_nxt = (cur_r.slot == own_slot);
          st_nxt   = B_RX_WR;
        end else begin
          st_nxt = B_IDLE;
        end
      end
      B_RX_WR: begin
        // raising our own entry stamps it with the new value itself
        ua_we    = 1'b1;
        ua_waddr = cur_r.slot;
        ua_wdata = same_r ? cur_r.value : cv_d;
        st_nxt   = B_IDLE;
      end
      B_SEND_LS: begin
        ls_nxt     = sa_d;
        issue_nxt  = '0;
        dv_nxt     = 1'b0;
        pend_v_nxt = 1'b0;
        st_nxt     = B_SCAN;
      end
      B_SCAN: begin
        if (!blocked) begin
          if (hit) begin
            if (pend_v_r) begin
              push     = 1'b1;
              push_idx = 4'(pend_idx_r);
              push_val = 32'(pend_val_r);
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = di_r;
            pend_val_nxt = cv_d;
          end
          if (issue_r < scan_n) begin
            cv_re     = 1'b1;
            cv_raddr  = issue_r[IDXW-1:0];
            ua_re     = 1'b1;
            ua_raddr  = issue_r[IDXW-1:0];
            di_nxt    = issue_r[IDXW-1:0];
            dv_nxt    = 1'b1;
            issue_nxt = cnt_t'(issue_r + 1'b1);
          end else begin
            dv_nxt = 1'b0;
            st_nxt = B_FLUSH;
          end
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (pend_v_r) begin
            push_idx = 4'(pend_idx_r);
            push_val = 32'(pend_val_r);
          end else begin
            push_empty = 1'b1;
          end
          pend_v_nxt = 1'b0;
          cv_re      = 1'b1;
          cv_raddr   = own_slot;
          st_nxt     = B_BUMP;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cv_vld_nxt = cv_vld_r;
    ua_vld_nxt = ua_vld_r;
    sa_vld_nxt = sa_vld_r;
    cv_rv_nxt  = cv_rv_r;
    ua_rv_nxt  = ua_rv_r;
    sa_rv_nxt  = sa_rv_r;
    if (cv_we) cv_vld_nxt[cv_waddr] = 1'b1;
    if (ua_we) ua_vld_nxt[ua_waddr] = 1'b1;
    if (sa_we) sa_vld_nxt[sa_waddr] = 1'b1;
    if (cv_re) cv_rv_nxt = cv_vld_r[cv_raddr];
    if (ua_re) ua_rv_nxt = ua_vld_r[ua_raddr];
    if (sa_re) sa_rv_nxt = sa_vld_r[sa_raddr];
  end

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_vld_nxt   = 1'b1;
      out_idx_nxt   = push_idx;
      out_val_nxt   = push_val;
      out_empty_nxt = push_empty;
      out_last_nxt  = push_last;
    end else if (out_res.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      dv_r      <= 1'b0;
      pend_v_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cv_vld_r  <= '0;
      ua_vld_r  <= '0;
      sa_vld_r  <= '0;
      cv_rv_r   <= 1'b0;
      ua_rv_r   <= 1'b0;
      sa_rv_r   <= 1'b0;
      issue_r   <= '0;
    end else begin
      st_r      <= st_nxt;
      dv_r      <= dv_nxt;
      pend_v_r  <= pend_v_nxt;
      out_vld_r <= out_vld_nxt;
      cv_vld_r  <= cv_vld_nxt;
      ua_vld_r  <= ua_vld_nxt;
      sa_vld_r  <= sa_vld_nxt;
      cv_rv_r   <= cv_rv_nxt;
      ua_rv_r   <= ua_rv_nxt;
      sa_rv_r   <= sa_rv_nxt;
      issue_r   <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    ls_r        <= ls_nxt;
    di_r        <= di_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_val_r  <= pend_val_nxt;
    same_r      <= same_nxt;
    out_idx_r   <= out_idx_nxt;
    out_val_r   <= out_val_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_res.valid     = out_vld_r;
  assign out_res.out_index = out_idx_r;
  assign out_res.out_value = out_val_r;
  assign out_res.empty_res = out_empty_r;
  assign out_res.last      = out_last_r;

`ifndef SYNTHESIS
  a_push_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (st_r == B_SCAN || st_r == B_FLUSH))
    else $error("result pushed outside a send");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_empty_r) |-> out_last_r)
    else $error("empty result without last");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SCAN) |-> (issue_r <= scan_n))
    else $error("scan index past process count");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SCAN) |-> (!cv_we && !ua_we && !sa_we))
    else $error("state written during send scan");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == B_IDLE && !q_empty))
    else $error("queue popped while busy");
`endif

endmodule

`default_nettype wire
